FILE: rtl/ttb_pkg.sv
// shared types, constants and helpers of the triangle tangent block
`timescale 1ns / 1ps
package ttb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int PROD_W        = 64;
   // quotient bits resolved below the overflow check
   localparam int QBITS         = 33;
   localparam int NLANE         = 6;
   localparam int REQ_W         = 480;
   localparam int RSP_W         = 192;

   typedef struct packed {
      logic [PROD_W-1:0]            dmag;
      logic                         dneg;
      logic                         degen;
      logic [NLANE-1:0]             nneg;
      logic [NLANE-1:0][PROD_W-1:0] nmag;
   } ttb_job_type;

   // a - b clamped to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] sat_sub(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d[COORD_W] != d[COORD_W-1]) begin
         sat_sub = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         sat_sub = d[COORD_W-1:0];
      end
   endfunction

   // a - b as {sign, magnitude}
   function automatic logic [PROD_W:0] sm_diff(
      input logic signed [PROD_W-1:0] a,
      input logic signed [PROD_W-1:0] b);
      logic signed [PROD_W:0] d;
      logic [PROD_W:0] m;
      d = {a[PROD_W-1], a} - {b[PROD_W-1], b};
      m = d[PROD_W] ? (-d) : d;
      sm_diff = {d[PROD_W], m[PROD_W-1:0]};
   endfunction

endpackage

FILE: rtl/ttb_front.sv
// front end: edges, uv deltas, products and sign-magnitude numerators
`timescale 1ns / 1ps
module ttb_front
   import ttb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [REQ_W-1:0] in_data,
   output logic             push,
   input  logic             full,
   output ttb_job_type      job
);

   logic signed [COORD_W-1:0] e1_ff [3];
   logic signed [COORD_W-1:0] e2_ff [3];
   logic signed [COORD_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [PROD_W-1:0]  pda_ff, pdb_ff;
   logic signed [PROD_W-1:0]  pta_ff [3];
   logic signed [PROD_W-1:0]  ptb_ff [3];
   logic signed [PROD_W-1:0]  pba_ff [3];
   logic signed [PROD_W-1:0]  pbb_ff [3];
   logic        v1_ff, v2_ff, v3_ff;
   logic        v1_in, v2_in, v3_in;
   ttb_job_type job_ff, job_in;
   logic        adv;
   logic [PROD_W:0] dsm;
   logic [PROD_W:0] tsm [3];
   logic [PROD_W:0] bsm [3];

   assign adv      = !v3_ff || !full;
   assign in_ready = adv;
   assign push     = v3_ff && !full;
   assign job      = job_ff;

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: saturated differences
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= sat_sub(in_data[(3+k)*COORD_W +: COORD_W], in_data[k*COORD_W +: COORD_W]);
            e2_ff[k] <= sat_sub(in_data[(6+k)*COORD_W +: COORD_W], in_data[k*COORD_W +: COORD_W]);
         end
         du1_ff <= sat_sub(in_data[352+32 +: 32], in_data[288+32 +: 32]);
         dv1_ff <= sat_sub(in_data[352 +: 32],    in_data[288 +: 32]);
         du2_ff <= sat_sub(in_data[416+32 +: 32], in_data[288+32 +: 32]);
         dv2_ff <= sat_sub(in_data[416 +: 32],    in_data[288 +: 32]);
      end
   end

   // stage 2: one 32x32 product per term
   always_ff @(posedge clock) begin
      if (adv) begin
         pda_ff <= du1_ff * dv2_ff;
         pdb_ff <= du2_ff * dv1_ff;
         for (int k = 0; k < 3; k++) begin
            pta_ff[k] <= dv2_ff * e1_ff[k];
            ptb_ff[k] <= dv1_ff * e2_ff[k];
            pba_ff[k] <= du1_ff * e2_ff[k];
            pbb_ff[k] <= du2_ff * e1_ff[k];
         end
      end
   end

   // stage 3: differences of products as sign and magnitude
   always_comb begin
      dsm = sm_diff(pda_ff, pdb_ff);
      for (int k = 0; k < 3; k++) begin
         tsm[k] = sm_diff(pta_ff[k], ptb_ff[k]);
         bsm[k] = sm_diff(pba_ff[k], pbb_ff[k]);
      end
      job_in.dmag  = dsm[PROD_W-1:0];
      job_in.dneg  = dsm[PROD_W];
      job_in.degen = (dsm[PROD_W-1:0] == '0);
      for (int k = 0; k < 3; k++) begin
         job_in.nmag[k]   = tsm[k][PROD_W-1:0];
         job_in.nneg[k]   = tsm[k][PROD_W];
         job_in.nmag[3+k] = bsm[k][PROD_W-1:0];
         job_in.nneg[3+k] = bsm[k][PROD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         job_ff <= job_in;
      end
   end

endmodule

FILE: rtl/ttb_fifo.sv
// short queue between front and back
`timescale 1ns / 1ps
module ttb_fifo
   import ttb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ttb_job_type push_data,
   output logic        full,
   input  logic        pop,
   output ttb_job_type pop_data,
   output logic        empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   ttb_job_type     mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ttb_div_lane.sv
// pipelined restoring divider with rounding and saturation, one bit a stage
`timescale 1ns / 1ps
module ttb_div_lane
   import ttb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  logic [PROD_W-1:0]   num,
   input  logic                nneg,
   input  logic [PROD_W-1:0]   den,
   input  logic                dneg,
   input  logic                kill,
   output logic [COORD_W-1:0]  res
);

   localparam int NW   = PROD_W + FRAC_BITS;
   localparam int TOPW = NW - QBITS;

   logic [NW-1:0]     nsh;
   logic [PROD_W-1:0] r_ff   [QBITS+1];
   logic [PROD_W-1:0] den_ff [QBITS+1];
   logic [QBITS-1:0]  q_ff   [QBITS+1];
   logic [QBITS-1:0]  low_ff [QBITS+1];
   logic              big_ff [QBITS+1];
   logic              neg_ff [QBITS+1];
   logic              kill_ff[QBITS+1];
   logic [COORD_W-1:0] res_ff, res_in;
   logic [PROD_W-1:0] top;

   assign nsh = {num, {FRAC_BITS{1'b0}}};
   assign top = {{(PROD_W-TOPW){1'b0}}, nsh[NW-1:QBITS]};
   assign res = res_ff;

   // entry: quotient of the high part must stay below 1, otherwise saturate
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= top;
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         low_ff[0]  <= nsh[QBITS-1:0];
         big_ff[0]  <= (top >= den);
         neg_ff[0]  <= nneg ^ dneg;
         kill_ff[0] <= kill;
      end
   end

   for (genvar s = 1; s <= QBITS; s++) begin : g_stage
      logic [PROD_W:0] trial;
      logic            ge;
      logic [PROD_W:0] diff;
      assign trial = {r_ff[s-1], low_ff[s-1][QBITS-s]};
      assign ge    = (trial >= {1'b0, den_ff[s-1]});
      assign diff  = trial - {1'b0, den_ff[s-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]    <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
            q_ff[s]    <= {q_ff[s-1][QBITS-2:0], ge};
            den_ff[s]  <= den_ff[s-1];
            low_ff[s]  <= low_ff[s-1];
            big_ff[s]  <= big_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            kill_ff[s] <= kill_ff[s-1];
         end
      end
   end

   // round half away from zero, then clamp
   always_comb begin
      logic            rnd;
      logic [QBITS:0]  q1;
      logic            sat;
      rnd = ({r_ff[QBITS], 1'b0} >= {1'b0, den_ff[QBITS]});
      q1  = {1'b0, q_ff[QBITS]} + (QBITS+1)'(rnd);
      sat = big_ff[QBITS] || (q1[QBITS:COORD_W-1] != '0);
      if (kill_ff[QBITS]) begin
         res_in = '0;
      end else if (neg_ff[QBITS]) begin
         res_in = sat ? {1'b1, {(COORD_W-1){1'b0}}} : (-q1[COORD_W-1:0]);
      end else begin
         res_in = sat ? {1'b0, {(COORD_W-1){1'b1}}} : q1[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule

FILE: rtl/ttb_back.sv
// back end: six divider lanes in lockstep and the result register
`timescale 1ns / 1ps
module ttb_back
   import ttb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   output logic             pop,
   input  ttb_job_type      job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [RSP_W-1:0] out_data,
   output logic             out_degen
);

   localparam int LAT = QBITS + 2;

   logic [LAT-1:0] vld_ff, vld_in;
   logic [LAT-1:0] dg_ff, dg_in;
   logic           adv;

   assign adv       = !vld_ff[LAT-1] || out_ready;
   assign pop       = adv && !empty;
   assign out_valid = vld_ff[LAT-1];
   assign out_degen = dg_ff[LAT-1];

   assign vld_in = {vld_ff[LAT-2:0], pop};
   assign dg_in  = {dg_ff[LAT-2:0], job.degen};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dg_ff <= dg_in;
      end
   end

   for (genvar i = 0; i < NLANE; i++) begin : g_lane
      ttb_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .en    (adv),
         .num   (job.nmag[i]),
         .nneg  (job.nneg[i]),
         .den   (job.dmag),
         .dneg  (job.dneg),
         .kill  (job.degen),
         .res   (out_data[i*COORD_W +: COORD_W])
      );
   end

endmodule

FILE: rtl/triangle_tangent_bitangent_top.sv
// top level of the triangle tangent and bitangent block
`timescale 1ns / 1ps
// One triangle per beat in, one tangent/bitangent pair per beat out, one beat per
// clock sustained while neither side stalls. The front end (3 stages: saturated
// edge and uv differences, 32x32 products, sign-magnitude differences) feeds a
// 4-entry queue; the back end runs six lockstep restoring dividers, one quotient
// bit per stage. A result passes through 3 front registers, 1 queue slot and 35
// back-end registers (entry, 33 divider stages, rounding), the first loaded at the
// accepting edge. Quotients are rounded half away from zero and saturated; a zero
// uv determinant returns zero vectors with the degenerate flag in rsp_tuser. Each
// side stalls on its own: the front holds when the queue is full, the back when
// the result register is not taken.
module triangle_tangent_bitangent_top
   import ttb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // pos1_x, pos1_y, pos1_z, pos2_x, pos2_y, pos2_z, pos3_x, pos3_y, pos3_z,
   // uv_first, uv_second, uv_third
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
   output logic [RSP_W-1:0] rsp_tdata,
   // degenerate
   output logic             rsp_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready
);

   ttb_job_type f_job, q_job;
   logic        push, full, pop, empty;

   // classify: differences and products per triangle
   ttb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .push     (push),
      .full     (full),
      .job      (f_job)
   );

   // decouples the front stall from the back stall
   ttb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (f_job),
      .full      (full),
      .pop       (pop),
      .pop_data  (q_job),
      .empty     (empty)
   );

   // divide, round, saturate
   ttb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop       (pop),
      .job       (q_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_degen (rsp_tuser)
   );

endmodule

FILE: rtl/ttb_checker.sv
// port-level checks of the triangle tangent block and their binding
`timescale 1ns / 1ps
module ttb_checker
   import ttb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   // degenerate beat carries zero vectors
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate beat with nonzero vectors");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind triangle_tangent_bitangent_top ttb_checker u_ttb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
